// ----- sv/grc_pkg.sv -----
// shared constants, command and result types and the angle table of the ray caster
package grc_pkg;

    localparam int MAP_ROWS    = 16;
    localparam int MAP_COLS    = 32;
    localparam int TILE_PIXELS = 64;

    localparam int ROW_W     = 4;
    localparam int COL_W     = 5;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int MAP_DEPTH = 1 << ADDR_W;
    localparam int CELL_W    = 4;

    localparam int ONE_PIXEL = 256;
    localparam int TILE_Q    = TILE_PIXELS * ONE_PIXEL;
    localparam int TILE_SH   = $clog2(TILE_Q);
    localparam int WIN_W     = MAP_COLS * TILE_Q;
    localparam int WIN_H     = MAP_ROWS * TILE_Q;

    localparam int PX_W     = 19;
    localparam int PY_W     = 18;
    localparam int ANGLE_W  = 16;
    localparam int FRAC_A_W = 14;
    localparam int STRIP_W  = 9;
    localparam int DIST_W   = 20;

    localparam int CX_W   = 20;
    localparam int CZ_W   = 17;
    localparam int CORD_N = 16;
    localparam int CORD_K = 39797;
    localparam int CS_ONE = 65536;
    localparam int CS_W   = 18;
    localparam int DVD_W  = 32;
    localparam int CRD_W  = 34;
    localparam int HC_W   = 20;
    localparam int DIFF_W = 21;
    localparam int D2_W   = 40;
    localparam int SQ_N   = D2_W / 2;

    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic                 is_ray;
        logic                 write_ok;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic [CELL_W-1:0]    value;
        logic [1:0]           quad;
        logic [FRAC_A_W-1:0]  frac;
        logic [STRIP_W-1:0]   strip;
        logic [PX_W-1:0]      px;
        logic [PY_W-1:0]      py;
        logic                 down;
        logic                 right;
    } t_cmd;

    typedef struct packed {
        logic [STRIP_W-1:0] strip_out;
        logic [DIST_W-1:0]  hit_distance;
        logic [PX_W-1:0]    hit_x;
        logic [PY_W-1:0]    hit_y;
        logic [CELL_W-1:0]  hit_content;
        logic               hit_vertical;
        logic               no_hit;
        logic               facing_down;
        logic               facing_right;
    } t_result;

    function automatic logic [13:0] atan_val(input logic [3:0] idx);
        logic [13:0] v;
        case (idx)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            4'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/grid_ray_caster.sv -----
// Tile-map ray caster: a classifier front end, a two-entry command queue, a
// ray engine and a one-entry result register. After reset the 512 cells of
// the map store are cleared while full stays high. A map write is done in the
// engine as it pops the command. A ray runs 16 CORDIC steps, up to four
// divisions in the shared divider (offset and step of each walk; a walk
// parallel to its grid lines is skipped along with its two divisions), one
// map store read per grid probe on each walk, the squared distances and 20
// square-root steps. The walk lengths, set by the map and the angle, make the
// run time of a ray vary.
module grid_ray_caster import grc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_mode,
    input  logic [ROW_W-1:0]   i_map_row,
    input  logic [COL_W-1:0]   i_map_col,
    input  logic [CELL_W-1:0]  i_map_value,
    input  logic [ANGLE_W-1:0] i_ray_angle,
    input  logic [STRIP_W-1:0] i_strip_id,
    input  logic [PX_W-1:0]    i_player_x,
    input  logic [PY_W-1:0]    i_player_y,
    output logic               empty,
    input  logic               pop,
    output logic [STRIP_W-1:0] o_strip_out,
    output logic [DIST_W-1:0]  o_hit_distance,
    output logic [PX_W-1:0]    o_hit_x,
    output logic [PY_W-1:0]    o_hit_y,
    output logic [CELL_W-1:0]  o_hit_content,
    output logic               o_hit_vertical,
    output logic               o_no_hit,
    output logic               o_facing_down,
    output logic               o_facing_right
);

    logic    clearing;
    logic    front_valid;
    t_cmd    front_cmd;
    logic    q_wr_ready;
    logic    q_valid;
    t_cmd    q_cmd;
    logic    q_pop;
    logic    res_valid;
    t_result res;
    logic    res_ready;
    logic    r_out_valid;
    t_result r_out;

    grc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (clearing),
        .i_push      (push),
        .o_full      (full),
        .i_mode      (i_mode),
        .i_map_row   (i_map_row),
        .i_map_col   (i_map_col),
        .i_map_value (i_map_value),
        .i_ray_angle (i_ray_angle),
        .i_strip_id  (i_strip_id),
        .i_player_x  (i_player_x),
        .i_player_y  (i_player_y),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (q_wr_ready)
    );

    grc_cmd_fifo u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (front_valid),
        .i_wdata    (front_cmd),
        .o_wr_ready (q_wr_ready),
        .o_rd_valid (q_valid),
        .o_rdata    (q_cmd),
        .i_rd       (q_pop)
    );

    grc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_clearing  (clearing),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    assign res_ready = !r_out_valid || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (res_valid && res_ready) || (r_out_valid && !pop);
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign empty          = !r_out_valid;
    assign o_strip_out    = r_out.strip_out;
    assign o_hit_distance = r_out.hit_distance;
    assign o_hit_x        = r_out.hit_x;
    assign o_hit_y        = r_out.hit_y;
    assign o_hit_content  = r_out.hit_content;
    assign o_hit_vertical = r_out.hit_vertical;
    assign o_no_hit       = r_out.no_hit;
    assign o_facing_down  = r_out.facing_down;
    assign o_facing_right = r_out.facing_right;

endmodule

// ----- sv/grc_front.sv -----
// input stage: takes transactions and classifies them into map writes and rays
module grc_front import grc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_hold,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic                 i_mode,
    input  logic [ROW_W-1:0]     i_map_row,
    input  logic [COL_W-1:0]     i_map_col,
    input  logic [CELL_W-1:0]    i_map_value,
    input  logic [ANGLE_W-1:0]   i_ray_angle,
    input  logic [STRIP_W-1:0]   i_strip_id,
    input  logic [PX_W-1:0]      i_player_x,
    input  logic [PY_W-1:0]      i_player_y,
    output logic                 o_cmd_valid,
    output t_cmd                 o_cmd,
    input  logic                 i_cmd_ready
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    assign o_full      = i_hold | (r_valid & ~i_cmd_ready);
    assign accept      = i_push & ~o_full;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_cmd.is_ray   = i_mode;
        n_cmd.write_ok = (int'(i_map_row) < MAP_ROWS) && (int'(i_map_col) < MAP_COLS);
        n_cmd.row      = i_map_row;
        n_cmd.col      = i_map_col;
        n_cmd.value    = i_map_value;
        n_cmd.quad     = i_ray_angle[ANGLE_W-1 -: 2];
        n_cmd.frac     = i_ray_angle[FRAC_A_W-1:0];
        n_cmd.strip    = i_strip_id;
        n_cmd.px       = i_player_x;
        n_cmd.py       = i_player_y;
        // strictly between zero and half turn
        n_cmd.down     = (i_ray_angle != '0) && !i_ray_angle[ANGLE_W-1];
        n_cmd.right    = (i_ray_angle < ANGLE_W'(16384)) || (i_ray_angle > ANGLE_W'(49152));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept | (r_valid & ~i_cmd_ready);
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ----- sv/grc_cmd_fifo.sv -----
// short command queue between the classifier and the ray engine
module grc_cmd_fifo import grc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wdata,
    output logic o_wr_ready,
    output logic o_rd_valid,
    output t_cmd o_rdata,
    input  logic i_rd
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_cmd             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_wr;
    logic             do_rd;

    assign o_wr_ready = r_cnt != CNT_W'(FIFO_DEPTH);
    assign o_rd_valid = r_cnt != '0;
    assign o_rdata    = r_mem[r_rp];
    assign do_wr      = i_wr & o_wr_ready;
    assign do_rd      = i_rd & o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (r_wp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= (r_rp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (do_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// ----- sv/grc_div.sv -----
// radix-2 restoring divider, one quotient bit per cycle
module grc_div import grc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [CS_W-1:0]  i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [CS_W-1:0]  r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [CS_W-1:0]  r_dvs;
    logic [CS_W:0]    shifted;
    logic             fits;
    logic [CS_W:0]    diff;

    assign shifted    = {r_rem, r_quo[DVD_W-1]};
    assign fits       = shifted >= {1'b0, r_dvs};
    assign diff       = shifted - {1'b0, r_dvs};
    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[CS_W-1:0] : shifted[CS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

endmodule

// ----- sv/grc_back.sv -----
// ray engine: map store, direction unit, grid walks, distance and square root
module grc_back import grc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    output logic    o_clearing,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_ready
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CORD, S_DIR, S_PHASE, S_DIVST, S_DIVW, S_WSET,
        S_WCHK, S_WRD, S_DIFF, S_SQ, S_SUM, S_PICK, S_SQRT, S_OUT
    } t_state;

    t_state r_state;

    logic [CELL_W-1:0] mem [MAP_DEPTH];
    logic [CELL_W-1:0] r_rd_data;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] rd_addr;

    logic [ADDR_W-1:0]       r_clr;
    logic [STRIP_W-1:0]      r_strip;
    logic [PX_W-1:0]         r_px;
    logic [PY_W-1:0]         r_py;
    logic                    r_down;
    logic                    r_right;
    logic [1:0]              r_quad;
    logic                    r_rzero;
    logic signed [CX_W-1:0]  r_cx;
    logic signed [CX_W-1:0]  r_cy;
    logic signed [CZ_W-1:0]  r_cz;
    logic [3:0]              r_it;
    logic [CS_W-1:0]         r_c;
    logic [CS_W-1:0]         r_s;
    logic                    r_phase;
    logic [CS_W-1:0]         r_num;
    logic [CS_W-1:0]         r_den;
    logic [HC_W-1:0]         r_line;
    logic [DVD_W-1:0]        r_prod;
    logic                    r_second;
    logic [DVD_W-1:0]        r_off;
    logic signed [CRD_W-1:0] r_wx;
    logic signed [CRD_W-1:0] r_wy;
    logic signed [CRD_W-1:0] r_wdx;
    logic signed [CRD_W-1:0] r_wdy;
    logic                    r_hit [2];
    logic [HC_W-1:0]         r_hx [2];
    logic [HC_W-1:0]         r_hy [2];
    logic [CELL_W-1:0]       r_hc [2];
    logic signed [DIFF_W-1:0] r_ddx;
    logic signed [DIFF_W-1:0] r_ddy;
    logic [D2_W-1:0]         r_sqx;
    logic [D2_W-1:0]         r_sqy;
    logic [D2_W-1:0]         r_d2 [2];
    logic                    r_pick_v;
    logic                    r_any;
    logic [D2_W-1:0]         r_sv;
    logic [D2_W-1:0]         r_sres;
    logic [D2_W-1:0]         r_sbit;
    logic [4:0]              r_sit;

    // divider hookup
    logic             div_start;
    logic             div_busy;
    logic             div_done;
    logic [DVD_W-1:0] div_q;

    // combinational helpers
    logic signed [CX_W-1:0]  cord_xs;
    logic signed [CX_W-1:0]  cord_ys;
    logic signed [CZ_W-1:0]  cord_at;
    logic [CS_W-1:0]         dir_cp;
    logic [CS_W-1:0]         dir_sp;
    logic [CS_W-1:0]         dir_c;
    logic [CS_W-1:0]         dir_s;
    logic [PX_W-1:0]         ph_grid;
    logic                    ph_pos;
    logic [HC_W-1:0]         ph_line;
    logic [HC_W-1:0]         ph_dist;
    logic [CS_W-1:0]         ph_num;
    logic [CS_W-1:0]         ph_den;
    logic signed [CRD_W-1:0] ws_off;
    logic signed [CRD_W-1:0] ws_step;
    logic signed [CRD_W-1:0] ws_tq;
    logic signed [CRD_W-1:0] ws_px;
    logic signed [CRD_W-1:0] ws_py;
    logic signed [CRD_W-1:0] ws_line;
    logic                    in_win;
    logic signed [CRD_W-1:0] pr_x;
    logic signed [CRD_W-1:0] pr_y;
    logic signed [CRD_W-1:0] pr_col;
    logic signed [CRD_W-1:0] pr_row;
    logic                    in_map;
    logic                    pick_v;
    logic [D2_W-1:0]         sq_sum;
    logic                    sel;
    logic [D2_W-1:0]         sq_prod_x;
    logic [D2_W-1:0]         sq_prod_y;

    grc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_den),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign div_start  = r_state == S_DIVST;
    assign o_clearing = r_state == S_CLEAR;
    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid;
    assign o_res_valid = r_state == S_OUT;

    // map store: clearing pass, cell writes and one probe read port
    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else begin
            mem_we    = o_cmd_pop && !i_cmd.is_ray && i_cmd.write_ok;
            mem_waddr = {i_cmd.row, i_cmd.col};
            mem_wdata = i_cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        cord_xs = r_cx >>> r_it;
        cord_ys = r_cy >>> r_it;
        cord_at = $signed({3'b000, atan_val(r_it)});

        dir_cp = (r_cx > 0) ? r_cx[CS_W-1:0] : '0;
        dir_sp = (r_cy > 0) ? r_cy[CS_W-1:0] : '0;
        if (r_rzero) begin
            dir_cp = CS_W'(CS_ONE);
            dir_sp = '0;
        end
        dir_c = r_quad[0] ? dir_sp : dir_cp;
        dir_s = r_quad[0] ? dir_cp : dir_sp;

        // first grid line crossed by the walk of this phase
        ph_grid = r_phase ? r_px : PX_W'(r_py);
        ph_pos  = r_phase ? r_right : r_down;
        ph_line = HC_W'({ph_grid[PX_W-1:TILE_SH], {TILE_SH{1'b0}}})
                + (ph_pos ? HC_W'(TILE_Q) : '0);
        ph_dist = ph_pos ? ph_line - HC_W'(ph_grid) : HC_W'(ph_grid) - ph_line;
        ph_num  = r_phase ? r_s : r_c;
        ph_den  = r_phase ? r_c : r_s;

        ws_off  = $signed({{(CRD_W-DVD_W){1'b0}}, r_off});
        ws_step = $signed({{(CRD_W-DVD_W){1'b0}}, div_q});
        ws_tq   = CRD_W'(TILE_Q);
        ws_px   = $signed({{(CRD_W-PX_W){1'b0}}, r_px});
        ws_py   = $signed({{(CRD_W-PY_W){1'b0}}, r_py});
        ws_line = $signed({{(CRD_W-HC_W){1'b0}}, r_line});

        in_win = (r_wx >= 0) && (r_wx <= CRD_W'(WIN_W))
              && (r_wy >= 0) && (r_wy <= CRD_W'(WIN_H));
        // probe sits one pixel back when walking toward smaller coordinates
        pr_x   = r_wx - ((r_phase && !r_right) ? CRD_W'(ONE_PIXEL) : '0);
        pr_y   = r_wy - ((!r_phase && !r_down) ? CRD_W'(ONE_PIXEL) : '0);
        pr_col = pr_x >>> TILE_SH;
        pr_row = pr_y >>> TILE_SH;
        in_map = (pr_x >= 0) && (pr_y >= 0)
              && (pr_col < CRD_W'(MAP_COLS)) && (pr_row < CRD_W'(MAP_ROWS));
        rd_addr = {pr_row[ROW_W-1:0], pr_col[COL_W-1:0]};

        sq_prod_x = D2_W'(r_ddx * r_ddx);
        sq_prod_y = D2_W'(r_ddy * r_ddy);

        // tie goes to the horizontal hit
        pick_v = r_hit[1] && (!r_hit[0] || (r_d2[1] < r_d2[0]));
        sq_sum = r_sres + r_sbit;
        sel    = r_pick_v;
    end

    always_comb begin
        o_res.strip_out    = r_strip;
        o_res.facing_down  = r_down;
        o_res.facing_right = r_right;
        if (r_any) begin
            o_res.hit_distance = (r_sres > D2_W'({DIST_W{1'b1}})) ? '1 : r_sres[DIST_W-1:0];
            o_res.hit_x        = (r_hx[sel] > HC_W'({PX_W{1'b1}})) ? '1 : r_hx[sel][PX_W-1:0];
            o_res.hit_y        = (r_hy[sel] > HC_W'({PY_W{1'b1}})) ? '1 : r_hy[sel][PY_W-1:0];
            o_res.hit_content  = r_hc[sel];
            o_res.hit_vertical = r_pick_v;
            o_res.no_hit       = 1'b0;
        end else begin
            o_res.hit_distance = '1;
            o_res.hit_x        = '0;
            o_res.hit_y        = '0;
            o_res.hit_content  = '0;
            o_res.hit_vertical = 1'b0;
            o_res.no_hit       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(MAP_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid && i_cmd.is_ray) begin
                        r_strip <= i_cmd.strip;
                        r_px    <= i_cmd.px;
                        r_py    <= i_cmd.py;
                        r_down  <= i_cmd.down;
                        r_right <= i_cmd.right;
                        r_quad  <= i_cmd.quad;
                        r_rzero <= i_cmd.frac == '0;
                        r_cx    <= CX_W'(CORD_K);
                        r_cy    <= '0;
                        r_cz    <= $signed({{(CZ_W-FRAC_A_W){1'b0}}, i_cmd.frac});
                        r_it    <= '0;
                        r_state <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (!r_cz[CZ_W-1]) begin
                        r_cx <= r_cx - cord_ys;
                        r_cy <= r_cy + cord_xs;
                        r_cz <= r_cz - cord_at;
                    end else begin
                        r_cx <= r_cx + cord_ys;
                        r_cy <= r_cy - cord_xs;
                        r_cz <= r_cz + cord_at;
                    end
                    r_it <= r_it + 1'b1;
                    if (r_it == 4'(CORD_N - 1)) begin
                        r_state <= S_DIR;
                    end
                end
                S_DIR: begin
                    r_c     <= dir_c;
                    r_s     <= dir_s;
                    r_phase <= 1'b0;
                    r_state <= S_PHASE;
                end
                S_PHASE: begin
                    if (ph_den == '0) begin
                        r_hit[r_phase] <= 1'b0;
                        r_phase        <= ~r_phase;
                        r_state        <= r_phase ? S_DIFF : S_PHASE;
                    end else begin
                        r_prod   <= DVD_W'(ph_dist[TILE_SH:0] * ph_num);
                        r_num    <= ph_num;
                        r_den    <= ph_den;
                        r_line   <= ph_line;
                        r_second <= 1'b0;
                        r_state  <= S_DIVST;
                    end
                end
                S_DIVST: begin
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (div_done) begin
                        if (!r_second) begin
                            r_off    <= div_q;
                            r_prod   <= DVD_W'(r_num) << TILE_SH;
                            r_second <= 1'b1;
                            r_state  <= S_DIVST;
                        end else begin
                            r_state <= S_WSET;
                        end
                    end
                end
                S_WSET: begin
                    if (!r_phase) begin
                        r_wx  <= r_right ? ws_px + ws_off : ws_px - ws_off;
                        r_wy  <= ws_line;
                        r_wdx <= r_right ? ws_step : -ws_step;
                        r_wdy <= r_down ? ws_tq : -ws_tq;
                    end else begin
                        r_wx  <= ws_line;
                        r_wy  <= r_down ? ws_py + ws_off : ws_py - ws_off;
                        r_wdx <= r_right ? ws_tq : -ws_tq;
                        r_wdy <= r_down ? ws_step : -ws_step;
                    end
                    r_state <= S_WCHK;
                end
                S_WCHK: begin
                    if (!in_win) begin
                        r_hit[r_phase] <= 1'b0;
                        r_phase        <= ~r_phase;
                        r_state        <= r_phase ? S_DIFF : S_PHASE;
                    end else if (!in_map) begin
                        // off-map probe is a wall of content zero
                        r_hit[r_phase] <= 1'b1;
                        r_hx[r_phase]  <= r_wx[HC_W-1:0];
                        r_hy[r_phase]  <= r_wy[HC_W-1:0];
                        r_hc[r_phase]  <= '0;
                        r_phase        <= ~r_phase;
                        r_state        <= r_phase ? S_DIFF : S_PHASE;
                    end else begin
                        r_state <= S_WRD;
                    end
                end
                S_WRD: begin
                    if (r_rd_data != '0) begin
                        r_hit[r_phase] <= 1'b1;
                        r_hx[r_phase]  <= r_wx[HC_W-1:0];
                        r_hy[r_phase]  <= r_wy[HC_W-1:0];
                        r_hc[r_phase]  <= r_rd_data;
                        r_phase        <= ~r_phase;
                        r_state        <= r_phase ? S_DIFF : S_PHASE;
                    end else begin
                        r_wx    <= r_wx + r_wdx;
                        r_wy    <= r_wy + r_wdy;
                        r_state <= S_WCHK;
                    end
                end
                S_DIFF: begin
                    r_ddx   <= $signed({1'b0, r_hx[r_phase]})
                             - $signed({{(DIFF_W-PX_W){1'b0}}, r_px});
                    r_ddy   <= $signed({1'b0, r_hy[r_phase]})
                             - $signed({{(DIFF_W-PY_W){1'b0}}, r_py});
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_sqx   <= sq_prod_x;
                    r_sqy   <= sq_prod_y;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_d2[r_phase] <= r_sqx + r_sqy;
                    r_phase       <= ~r_phase;
                    r_state       <= r_phase ? S_PICK : S_DIFF;
                end
                S_PICK: begin
                    r_pick_v <= pick_v;
                    r_any    <= r_hit[0] | r_hit[1];
                    r_sv     <= pick_v ? r_d2[1] : r_d2[0];
                    r_sres   <= '0;
                    r_sbit   <= D2_W'(1) << (D2_W - 2);
                    r_sit    <= '0;
                    r_state  <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_sv >= sq_sum) begin
                        r_sv   <= r_sv - sq_sum;
                        r_sres <= (r_sres >> 1) + r_sbit;
                    end else begin
                        r_sres <= r_sres >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                    r_sit  <= r_sit + 1'b1;
                    if (r_sit == 5'(SQ_N - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_CLEAR |=> r_state != S_CLEAR)
        else $error("clearing pass restarted");

    a_probe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WRD |-> $past(r_state) == S_WCHK)
        else $error("map data used without a probe read");

    a_nohit_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.no_hit |-> o_res.hit_distance == '1 && !o_res.hit_vertical)
        else $error("miss result not saturated");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

endmodule

// ----- tb/grid_ray_caster_tb.sv -----
// testbench for the tile-map ray caster: map writes go into a local model and rays are checked against it
`timescale 1ns / 100ps

module grid_ray_caster_tb;
    import grc_pkg::*;

    localparam int RANDOM_ITEMS = 1730;
    localparam int QUIET_ITEMS  = 200;

    typedef struct {
        logic               mode;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [CELL_W-1:0]  value;
        logic [ANGLE_W-1:0] angle;
        logic [STRIP_W-1:0] strip;
        logic [PX_W-1:0]    px;
        logic [PY_W-1:0]    py;
        logic               typed;
        t_result            res;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               pop = 1'b0;
    logic               full, empty;
    logic               i_mode = 1'b0;
    logic [ROW_W-1:0]   i_map_row = '0;
    logic [COL_W-1:0]   i_map_col = '0;
    logic [CELL_W-1:0]  i_map_value = '0;
    logic [ANGLE_W-1:0] i_ray_angle = '0;
    logic [STRIP_W-1:0] i_strip_id = '0;
    logic [PX_W-1:0]    i_player_x = '0;
    logic [PY_W-1:0]    i_player_y = '0;
    t_result            got;

    logic [CELL_W-1:0] cells [MAP_DEPTH];
    t_result           hit_q [$];
    t_row              table_q [$];
    t_row              typed_q [$];
    int                errors = 0;
    int                n_rays = 0, n_writes = 0, n_vert = 0, n_miss = 0;
    bit                quiet = 0;
    int                pop_idle = 0;

    grid_ray_caster dut (
        .i_clk, .i_rst_n, .push, .full, .i_mode, .i_map_row, .i_map_col,
        .i_map_value, .i_ray_angle, .i_strip_id, .i_player_x, .i_player_y,
        .empty, .pop,
        .o_strip_out(got.strip_out), .o_hit_distance(got.hit_distance),
        .o_hit_x(got.hit_x), .o_hit_y(got.hit_y), .o_hit_content(got.hit_content),
        .o_hit_vertical(got.hit_vertical), .o_no_hit(got.no_hit),
        .o_facing_down(got.facing_down), .o_facing_right(got.facing_right)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("timeout at %0t", $time);
        $display("TEST FAILED");
        $finish;
    end

    // rotate (K, 0) by the fraction of a quadrant
    function automatic void unit_dir(input longint r, output longint c, output longint s);
        longint x, y, z, xs, ys;
        x = CORD_K;
        y = 0;
        z = r;
        if (r == 0) begin
            c = CS_ONE;
            s = 0;
            return;
        end
        for (int i = 0; i < CORD_N; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_val(i);
            end else begin
                x += ys; y -= xs; z += atan_val(i);
            end
        end
        c = x > 0 ? x : 0;
        s = y > 0 ? y : 0;
    endfunction

    // step along grid lines until a wall or out of the window
    function automatic bit grid_walk(input longint x, input longint y, input longint dx,
                                     input longint dy, input longint ox, input longint oy,
                                     output longint hx, output longint hy,
                                     output longint hc);
        longint prx, pry, v;
        bit wall;
        while (x >= 0 && x <= WIN_W && y >= 0 && y <= WIN_H) begin
            prx = x + ox;
            pry = y + oy;
            v = 0;
            wall = 1;
            if (prx >= 0 && pry >= 0 && prx / TILE_Q < MAP_COLS && pry / TILE_Q < MAP_ROWS) begin
                v = cells[(pry / TILE_Q) * MAP_COLS + prx / TILE_Q];
                wall = v != 0;
            end
            if (wall) begin
                hx = x; hy = y; hc = v;
                return 1;
            end
            x += dx;
            y += dy;
        end
        return 0;
    endfunction

    function automatic longint int_sqrt(input longint v);
        longint res, b;
        res = 0;
        b = longint'(1) << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic t_result cast_ray(input logic [ANGLE_W-1:0] angle,
                                         input logic [STRIP_W-1:0] strip,
                                         input longint px, input longint py);
        t_result r;
        bit down, right, hh, vh, pick_v;
        longint c, s, t, ty, tx, off, st, hx, hy, hc, vx, vy, vc, hd2, vd2, d;
        hh = 0; vh = 0; hd2 = 0; vd2 = 0;
        hx = 0; hy = 0; hc = 0; vx = 0; vy = 0; vc = 0;
        down = angle > 0 && angle < 32768;
        right = angle < 16384 || angle > 49152;
        unit_dir(angle[FRAC_A_W-1:0], c, s);
        if (angle[FRAC_A_W]) begin
            t = c; c = s; s = t;
        end
        if (s != 0) begin
            ty = (py / TILE_Q) * TILE_Q + (down ? TILE_Q : 0);
            off = ((down ? ty - py : py - ty) * c) / s;
            st = (TILE_Q * c) / s;
            hh = grid_walk(right ? px + off : px - off, ty, right ? st : -st,
                           down ? TILE_Q : -TILE_Q, 0, down ? 0 : -ONE_PIXEL, hx, hy, hc);
        end
        if (c != 0) begin
            tx = (px / TILE_Q) * TILE_Q + (right ? TILE_Q : 0);
            off = ((right ? tx - px : px - tx) * s) / c;
            st = (TILE_Q * s) / c;
            vh = grid_walk(tx, down ? py + off : py - off, right ? TILE_Q : -TILE_Q,
                           down ? st : -st, right ? 0 : -ONE_PIXEL, 0, vx, vy, vc);
        end
        if (hh) hd2 = (hx - px) * (hx - px) + (hy - py) * (hy - py);
        if (vh) vd2 = (vx - px) * (vx - px) + (vy - py) * (vy - py);
        pick_v = vh && (!hh || vd2 < hd2);
        r = '0;
        r.strip_out = strip;
        if (pick_v || hh) begin
            d = int_sqrt(pick_v ? vd2 : hd2);
            t = pick_v ? vx : hx;
            r.hit_x = t < 0 ? 0 : (t > 'h7FFFF ? 'h7FFFF : t);
            t = pick_v ? vy : hy;
            r.hit_y = t < 0 ? 0 : (t > 'h3FFFF ? 'h3FFFF : t);
            r.hit_distance = d > 'hFFFFF ? 'hFFFFF : d;
            r.hit_content = pick_v ? vc : hc;
            r.hit_vertical = pick_v;
        end else begin
            r.hit_distance = '1;
            r.no_hit = 1'b1;
        end
        r.facing_down = down;
        r.facing_right = right;
        return r;
    endfunction

    // input side: model every accepted transaction
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            if (!i_mode) begin
                cells[{i_map_row, i_map_col}] = i_map_value;
                n_writes++;
            end else begin
                t_result e;
                t_row    tr;
                e = cast_ray(i_ray_angle, i_strip_id, i_player_x, i_player_y);
                if (typed_q.size() != 0 && typed_q[0].angle == i_ray_angle &&
                    typed_q[0].strip == i_strip_id) begin
                    tr = typed_q.pop_front();
                    e = tr.res;
                end
                hit_q.push_back(e);
                n_rays++;
            end
        end
    end

    task automatic cmp(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // result side: random pop bursts and checking
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (hit_q.size() == 0) begin
                $display("%0t: unexpected result, strip %0d", $time, got.strip_out);
                errors++;
            end else begin
                t_result e;
                e = hit_q.pop_front();
                cmp("strip_out", e.strip_out, got.strip_out);
                cmp("hit_distance", e.hit_distance, got.hit_distance);
                cmp("hit_x", e.hit_x, got.hit_x);
                cmp("hit_y", e.hit_y, got.hit_y);
                cmp("hit_content", e.hit_content, got.hit_content);
                cmp("hit_vertical", e.hit_vertical, got.hit_vertical);
                cmp("no_hit", e.no_hit, got.no_hit);
                cmp("facing_down", e.facing_down, got.facing_down);
                cmp("facing_right", e.facing_right, got.facing_right);
                n_vert += got.hit_vertical;
                n_miss += got.no_hit;
            end
        end
        if (pop_idle > 0) begin
            pop_idle--;
            pop <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            pop_idle = $urandom_range(0, 6);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic send(input t_row it);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_mode <= it.mode;
        i_map_row <= it.row;
        i_map_col <= it.col;
        i_map_value <= it.value;
        i_ray_angle <= it.angle;
        i_strip_id <= it.strip;
        i_player_x <= it.px;
        i_player_y <= it.py;
        do @(posedge i_clk); while (full);
    endtask

    function automatic t_row cell_write(input int r, input int c, input int v);
        t_row it;
        it = '{default: '0};
        it.row = r; it.col = c; it.value = v;
        return it;
    endfunction

    function automatic t_row ray(input int a, input int st, input int x, input int y);
        t_row it;
        it = '{default: '0};
        it.mode = 1'b1; it.angle = a; it.strip = st; it.px = x; it.py = y;
        return it;
    endfunction

    function automatic t_row random_item();
        t_row it;
        int a;
        if ($urandom_range(0, 3) == 0)
            return cell_write($urandom, $urandom,
                              $urandom_range(0, 1) ? 0 : $urandom_range(1, 15));
        a = $urandom_range(0, 65535);
        if ($urandom_range(0, 9) == 0) a = 8192 * $urandom_range(0, 7) + $urandom_range(0, 2) - 1;
        it = ray(a & 16'hFFFF, $urandom_range(0, 511), $urandom_range(0, 524287),
                 $urandom_range(0, 262143));
        return it;
    endfunction

    initial begin
        t_row it;
        // empty map: rays run to the window edge, which counts as a wall of content 0
        it = ray(0, 5, 0, 0);
        it.typed = 1;
        it.res = '{strip_out: 5, hit_distance: 524288, hit_x: 'h7FFFF, hit_y: 0,
                   hit_content: 0, hit_vertical: 1, no_hit: 0, facing_down: 0,
                   facing_right: 1};
        table_q.push_back(it);
        it = ray(16384, 511, 0, 0);
        it.typed = 1;
        it.res = '{strip_out: 511, hit_distance: 262144, hit_x: 0, hit_y: 'h3FFFF,
                   hit_content: 0, hit_vertical: 0, no_hit: 0, facing_down: 1,
                   facing_right: 0};
        table_q.push_back(it);
        table_q.push_back(ray(32768, 0, 524287, 262143));
        table_q.push_back(ray(49152, 100, 262144, 131072));
        table_q.push_back(ray(65535, 200, 300000, 100000));
        table_q.push_back(ray(1, 300, 100, 100));
        table_q.push_back(ray(16383, 301, 70000, 70000));
        table_q.push_back(ray(16385, 302, 400000, 200000));
        table_q.push_back(ray(8192, 303, 8192, 8192));
        // walls at both corners and around the middle, then rays from inside
        table_q.push_back(cell_write(15, 31, 15));
        table_q.push_back(cell_write(4, 8, 7));
        table_q.push_back(cell_write(8, 16, 9));
        table_q.push_back(cell_write(8, 17, 3));
        table_q.push_back(cell_write(0, 0, 1));
        table_q.push_back(ray(0, 10, 8 * TILE_Q + 100, 8 * TILE_Q + 200));
        table_q.push_back(ray(40960, 11, 9 * TILE_Q + 5000, 10 * TILE_Q + 300));
        table_q.push_back(ray(24576, 12, 2 * TILE_Q, TILE_Q + 10));
        table_q.push_back(ray(57344, 13, 16 * TILE_Q + 8000, 9 * TILE_Q + 8000));
        table_q.push_back(ray(45000, 14, 100, 100));
        table_q.push_back(cell_write(0, 0, 0));
        table_q.push_back(ray(45000, 15, 100, 100));
        foreach (table_q[i]) if (table_q[i].typed) typed_q.push_back(table_q[i]);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (cells[i]) cells[i] = '0;

        foreach (table_q[i]) send(table_q[i]);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                push <= 1'b0;
                // let the input monitor log the last accepted ray first
                @(posedge i_clk);
                wait (hit_q.size() == 0);
                @(posedge i_clk);
            end
            if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1;
            send(random_item());
        end
        push <= 1'b0;
        @(posedge i_clk);
        wait (hit_q.size() == 0);
        repeat (400) @(posedge i_clk);

        $display("%0d map writes, %0d rays (%0d vertical hits, %0d misses)",
                 n_writes, n_rays, n_vert, n_miss);
        if (errors == 0 && hit_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, hit_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
